// ===== rtl/oriented_box_overlap_hit_unit_macros.svh =====
// ----------------------------------------------------------------------------
// oriented_box_overlap_hit_unit_macros
// Assertion shorthands for the overlap hit unit.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_OVERLAP_HIT_UNIT_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_HIT_UNIT_MACROS_SVH

// same-cycle implication
`define OBOX_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OBOX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/obox_pkg.sv =====
// ----------------------------------------------------------------------------
// obox_pkg
// Shared constants and types of the oriented box overlap hit unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obox_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS   = 14;

    localparam int IN_DATA_W  = 320;
    localparam int OUT_DATA_W = 64;

    localparam int NUM_W  = 50;
    localparam int DEN_W  = 32;
    localparam int QUOT_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // one classified request, ready for the divide
    typedef struct packed {
        logic                    hit;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic [15:0]             nx;
        logic [15:0]             ny;
    } obox_job_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } obox_fifo_stat_t;

endpackage

// ===== rtl/oriented_box_overlap_hit_unit.sv =====
// ----------------------------------------------------------------------------
// oriented_box_overlap_hit_unit
// Separating-axis overlap of two oriented boxes with contact parameter.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room, and returns one result
// per request, in order. Requests pass the axis tests and face choice, wait in
// the 4-entry queue, then go through divide and output: the contact
// parameter comes from a 32-stage restoring divider that resolves one
// quotient bit per stage. Output stalls hold the divider; the classifier
// keeps running until the queue fills.
`timescale 1ns / 1ps

`include "oriented_box_overlap_hit_unit_macros.svh"

module oriented_box_overlap_hit_unit
    import obox_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // box_x, box_y, box_dir_x, box_dir_y, box_half_width, box_half_length,
    // rect_x, rect_y, rect_dir_x, rect_dir_y, rect_half_x, rect_half_y, pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit_param, normal_x, normal_y
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // hit
    output logic                  m_axis_tuser
);

    logic            front_valid, front_ready;
    obox_job_t       front_job;
    logic            fifo_valid, fifo_ready, fifo_pop;
    obox_job_t       fifo_job;
    obox_fifo_stat_t fifo_stat;

    obox_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    obox_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_job),
        .pop_valid  (fifo_valid),
        .pop_ready  (fifo_ready),
        .pop_item   (fifo_job),
        .stat       (fifo_stat)
    );

    obox_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (fifo_valid),
        .job_ready (fifo_ready),
        .job       (fifo_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_hit   (m_axis_tuser)
    );

    assign fifo_pop = fifo_valid && fifo_ready;

    `OBOX_ASSERT_SAME(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "miss carries nonzero payload")
    `OBOX_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_stat.count <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
    `OBOX_ASSERT_NEXT(a_fifo_hold, fifo_stat.full && !fifo_pop, fifo_stat.full, "queue lost entry")

endmodule

// ===== rtl/obox_front.sv =====
// ----------------------------------------------------------------------------
// obox_front
// Separating-axis tests, contact face choice and divide operand selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obox_front
    import obox_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_DATA_W-1:0] in_data,
    output logic                 job_valid,
    input  logic                 job_ready,
    output obox_job_t            job
);

    localparam int D = DIR_FRAC_BITS;

    logic       en;
    logic [6:0] v_reg;

    logic signed [31:0] box_x, box_y, rect_x, rect_y;
    logic signed [15:0] bdx, bdy, rdx, rdy;

    assign box_x  = $signed(in_data[31:0]);
    assign box_y  = $signed(in_data[63:32]);
    assign bdx    = $signed(in_data[79:64]);
    assign bdy    = $signed(in_data[95:80]);
    assign rect_x = $signed(in_data[189:158]);
    assign rect_y = $signed(in_data[221:190]);
    assign rdx    = $signed(in_data[237:222]);
    assign rdy    = $signed(in_data[253:238]);

    assign en        = !v_reg[6] || job_ready;
    assign in_ready  = en;
    assign job_valid = v_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    // stage 1: deltas and direction products
    logic signed [32:0] dx_next, dy_next, pl_next, pw_next;
    logic signed [32:0] dx1_reg, dy1_reg, pl1_reg, pw1_reg;
    logic signed [15:0] bdx1_reg, bdy1_reg, rdx1_reg, rdy1_reg;
    logic [30:0]        hw1_reg, hl1_reg, rhx1_reg, rhy1_reg;

    assign dx_next = box_x - rect_x;
    assign dy_next = box_y - rect_y;
    assign pl_next = rdx * bdx + rdy * bdy;
    assign pw_next = rdx * bdy - rdy * bdx;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            pl1_reg  <= pl_next;
            pw1_reg  <= pw_next;
            bdx1_reg <= bdx;
            bdy1_reg <= bdy;
            rdx1_reg <= rdx;
            rdy1_reg <= rdy;
            hw1_reg  <= in_data[126:96];
            hl1_reg  <= in_data[157:127];
            rhx1_reg <= in_data[284:254];
            rhy1_reg <= in_data[315:285];
        end
    end

    // stage 2: delta projections, |pL|, |pW|
    logic signed [47:0] xry_next, yrx_next, xrx_next, yry_next;
    logic signed [47:0] xbx_next, yby_next, xby_next, ybx_next;
    logic signed [47:0] xry_reg, yrx_reg, xrx_reg, yry_reg;
    logic signed [47:0] xbx_reg, yby_reg, xby_reg, ybx_reg;
    logic [31:0]        pla_next, pwa_next, pla2_reg, pwa2_reg;
    logic               pl_pos2_reg, pw_pos2_reg;
    logic signed [15:0] bdx2_reg, bdy2_reg;
    logic [30:0]        hw2_reg, hl2_reg, rhx2_reg, rhy2_reg;

    assign xry_next = dx1_reg * rdy1_reg;
    assign yrx_next = dy1_reg * rdx1_reg;
    assign xrx_next = dx1_reg * rdx1_reg;
    assign yry_next = dy1_reg * rdy1_reg;
    assign xbx_next = dx1_reg * bdx1_reg;
    assign yby_next = dy1_reg * bdy1_reg;
    assign xby_next = dx1_reg * bdy1_reg;
    assign ybx_next = dy1_reg * bdx1_reg;
    assign pla_next = pl1_reg[32] ? 32'(-pl1_reg) : pl1_reg[31:0];
    assign pwa_next = pw1_reg[32] ? 32'(-pw1_reg) : pw1_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xry_reg     <= xry_next;
            yrx_reg     <= yrx_next;
            xrx_reg     <= xrx_next;
            yry_reg     <= yry_next;
            xbx_reg     <= xbx_next;
            yby_reg     <= yby_next;
            xby_reg     <= xby_next;
            ybx_reg     <= ybx_next;
            pla2_reg    <= pla_next;
            pwa2_reg    <= pwa_next;
            pl_pos2_reg <= !pl1_reg[32] && (pl1_reg != '0);
            pw_pos2_reg <= !pw1_reg[32] && (pw1_reg != '0);
            bdx2_reg    <= bdx1_reg;
            bdy2_reg    <= bdy1_reg;
            hw2_reg     <= hw1_reg;
            hl2_reg     <= hl1_reg;
            rhx2_reg    <= rhx1_reg;
            rhy2_reg    <= rhy1_reg;
        end
    end

    // stage 3: projection sums, weighted half sizes
    logic signed [49:0] dcr_next, ddr_next, ddb_next, dcb_next;
    logic signed [49:0] dcr_reg, ddr_reg, ddb_reg, dcb_reg;
    logic [62:0]        lw_reg, wl_reg, ww_reg, ll_reg;
    logic [62:0]        lrx_reg, wry_reg, wrx_reg, lry_reg;
    logic [31:0]        pla3_reg, pwa3_reg;
    logic               pl_pos3_reg, pw_pos3_reg;
    logic signed [15:0] bdx3_reg, bdy3_reg;
    logic [30:0]        hw3_reg, hl3_reg, rhx3_reg, rhy3_reg;

    assign dcr_next = xry_reg - yrx_reg;
    assign ddr_next = xrx_reg + yry_reg;
    assign ddb_next = xbx_reg + yby_reg;
    assign dcb_next = xby_reg - ybx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dcr_reg     <= dcr_next;
            ddr_reg     <= ddr_next;
            ddb_reg     <= ddb_next;
            dcb_reg     <= dcb_next;
            lw_reg      <= pla2_reg * hw2_reg;
            wl_reg      <= pwa2_reg * hl2_reg;
            ww_reg      <= pwa2_reg * hw2_reg;
            ll_reg      <= pla2_reg * hl2_reg;
            lrx_reg     <= pla2_reg * rhx2_reg;
            wry_reg     <= pwa2_reg * rhy2_reg;
            wrx_reg     <= pwa2_reg * rhx2_reg;
            lry_reg     <= pla2_reg * rhy2_reg;
            pla3_reg    <= pla2_reg;
            pwa3_reg    <= pwa2_reg;
            pl_pos3_reg <= pl_pos2_reg;
            pw_pos3_reg <= pw_pos2_reg;
            bdx3_reg    <= bdx2_reg;
            bdy3_reg    <= bdy2_reg;
            hw3_reg     <= hw2_reg;
            hl3_reg     <= hl2_reg;
            rhx3_reg    <= rhx2_reg;
            rhy3_reg    <= rhy2_reg;
        end
    end

    // stage 4: magnitudes, bounds, contact offsets
    logic [63:0]        s_cr, s_dr, s_db, s_cb;
    logic [49:0]        mcr_next, mdr_next, mdb_next, mcb_next;
    logic [49:0]        mcr_reg, mdr_reg, mdb_reg, mcb_reg;
    logic [50:0]        bcr_next, bdr_next, bdb_next, bcb_next;
    logic [50:0]        bcr_reg, bdr_reg, bdb_reg, bcb_reg;
    logic signed [49:0] hwd, hld, b1_next, b2_next, b1_reg, b2_reg;
    logic [31:0]        pla4_reg, pwa4_reg;
    logic               pl_pos4_reg, pw_pos4_reg;
    logic signed [15:0] bdx4_reg, bdy4_reg;

    assign s_cr = 64'(lw_reg) + 64'(wl_reg);
    assign s_dr = 64'(ww_reg) + 64'(ll_reg);
    assign s_db = 64'(lrx_reg) + 64'(wry_reg);
    assign s_cb = 64'(wrx_reg) + 64'(lry_reg);

    assign bcr_next = 51'({rhy3_reg, {D{1'b0}}}) + 51'(s_cr >> D);
    assign bdr_next = 51'({rhx3_reg, {D{1'b0}}}) + 51'(s_dr >> D);
    assign bdb_next = 51'({hl3_reg, {D{1'b0}}}) + 51'(s_db >> D);
    assign bcb_next = 51'({hw3_reg, {D{1'b0}}}) + 51'(s_cb >> D);

    assign mcr_next = dcr_reg[49] ? -dcr_reg : dcr_reg;
    assign mdr_next = ddr_reg[49] ? -ddr_reg : ddr_reg;
    assign mdb_next = ddb_reg[49] ? -ddb_reg : ddb_reg;
    assign mcb_next = dcb_reg[49] ? -dcb_reg : dcb_reg;

    assign hwd     = $signed(50'({hw3_reg, {D{1'b0}}}));
    assign hld     = $signed(50'({hl3_reg, {D{1'b0}}}));
    assign b1_next = (pw_pos3_reg ? dcb_reg : -dcb_reg) - hwd;
    assign b2_next = (pl_pos3_reg ? ddb_reg : -ddb_reg) - hld;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mcr_reg     <= mcr_next;
            mdr_reg     <= mdr_next;
            mdb_reg     <= mdb_next;
            mcb_reg     <= mcb_next;
            bcr_reg     <= bcr_next;
            bdr_reg     <= bdr_next;
            bdb_reg     <= bdb_next;
            bcb_reg     <= bcb_next;
            b1_reg      <= b1_next;
            b2_reg      <= b2_next;
            pla4_reg    <= pla3_reg;
            pwa4_reg    <= pwa3_reg;
            pl_pos4_reg <= pl_pos3_reg;
            pw_pos4_reg <= pw_pos3_reg;
            bdx4_reg    <= bdx3_reg;
            bdy4_reg    <= bdy3_reg;
        end
    end

    // stage 5: axis verdict, partial products of the face compare
    logic               hit_next, hit5_reg;
    logic signed [57:0] p1h_next, p2h_next, p1h_reg, p2h_reg;
    logic [56:0]        p1l_reg, p2l_reg;
    logic signed [49:0] b1_5_reg, b2_5_reg;
    logic [31:0]        pla5_reg, pwa5_reg;
    logic               pl_pos5_reg, pw_pos5_reg;
    logic signed [15:0] bdx5_reg, bdy5_reg;

    assign hit_next = ({1'b0, mcr_reg} <= bcr_reg) && ({1'b0, mdr_reg} <= bdr_reg)
                   && ({1'b0, mdb_reg} <= bdb_reg) && ({1'b0, mcb_reg} <= bcb_reg);
    assign p1h_next = $signed(b1_reg[49:25]) * $signed({1'b0, pla4_reg});
    assign p2h_next = $signed(b2_reg[49:25]) * $signed({1'b0, pwa4_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit5_reg    <= hit_next;
            p1h_reg     <= p1h_next;
            p2h_reg     <= p2h_next;
            p1l_reg     <= b1_reg[24:0] * pla4_reg;
            p2l_reg     <= b2_reg[24:0] * pwa4_reg;
            b1_5_reg    <= b1_reg;
            b2_5_reg    <= b2_reg;
            pla5_reg    <= pla4_reg;
            pwa5_reg    <= pwa4_reg;
            pl_pos5_reg <= pl_pos4_reg;
            pw_pos5_reg <= pw_pos4_reg;
            bdx5_reg    <= bdx4_reg;
            bdy5_reg    <= bdy4_reg;
        end
    end

    // stage 6: full products b1*|pL| and b2*|pW|
    logic signed [83:0] p1h_ext, p2h_ext, prod1_next, prod2_next, prod1_reg, prod2_reg;
    logic               hit6_reg;
    logic signed [49:0] b1_6_reg, b2_6_reg;
    logic [31:0]        pla6_reg, pwa6_reg;
    logic               pl_pos6_reg, pw_pos6_reg;
    logic signed [15:0] bdx6_reg, bdy6_reg;

    assign p1h_ext    = p1h_reg;
    assign p2h_ext    = p2h_reg;
    assign prod1_next = (p1h_ext <<< 25) + $signed({27'b0, p1l_reg});
    assign prod2_next = (p2h_ext <<< 25) + $signed({27'b0, p2l_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg   <= prod1_next;
            prod2_reg   <= prod2_next;
            hit6_reg    <= hit5_reg;
            b1_6_reg    <= b1_5_reg;
            b2_6_reg    <= b2_5_reg;
            pla6_reg    <= pla5_reg;
            pwa6_reg    <= pwa5_reg;
            pl_pos6_reg <= pl_pos5_reg;
            pw_pos6_reg <= pw_pos5_reg;
            bdx6_reg    <= bdx5_reg;
            bdy6_reg    <= bdy5_reg;
        end
    end

    // stage 7: face choice
    logic      width_face;
    obox_job_t job_next, job_reg;

    assign width_face = prod1_reg > prod2_reg;

    always_comb
    begin
        job_next.hit = hit6_reg;
        if (width_face)
        begin
            job_next.num = b1_6_reg;
            job_next.den = pwa6_reg;
            job_next.nx  = pw_pos6_reg ? -bdy6_reg : bdy6_reg;
            job_next.ny  = pw_pos6_reg ? bdx6_reg : -bdx6_reg;
        end
        else
        begin
            job_next.num = b2_6_reg;
            job_next.den = pla6_reg;
            job_next.nx  = pl_pos6_reg ? -bdx6_reg : bdx6_reg;
            job_next.ny  = pl_pos6_reg ? -bdy6_reg : bdy6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_reg <= job_next;
        end
    end

    assign job = job_reg;

endmodule

// ===== rtl/obox_fifo.sv =====
// ----------------------------------------------------------------------------
// obox_fifo
// Short request queue between the classifier and the divide pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obox_fifo
    import obox_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  obox_job_t       push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output obox_job_t       pop_item,
    output obox_fifo_stat_t stat
);

    obox_job_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               push, pop;

    assign push_ready = count_reg != FIFO_CW'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign stat.full  = !push_ready;
    assign stat.empty = !pop_valid;
    assign stat.count = count_reg;

endmodule

// ===== rtl/obox_back.sv =====
// ----------------------------------------------------------------------------
// obox_back
// Pipelined restoring divide of the contact offset, saturation, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obox_back
    import obox_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  obox_job_t             job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_hit
);

    localparam int D = DIR_FRAC_BITS;

    typedef struct packed {
        logic        hit;
        logic        neg;
        logic        ovf;
        logic        zero;
        logic [15:0] nx;
        logic [15:0] ny;
    } meta_t;

    logic en;
    logic [QUOT_W:0] v_reg;

    meta_t             meta_reg [QUOT_W+1];
    logic [DEN_W-1:0]  den_reg  [QUOT_W+1];
    logic [DEN_W-1:0]  rem_reg  [QUOT_W+1];
    logic [QUOT_W-1:0] lo_reg   [QUOT_W+1];
    logic [QUOT_W-1:0] q_reg    [QUOT_W+1];

    logic              out_valid_reg, out_hit_reg;
    logic [31:0]       param_reg, param_next;
    logic [15:0]       nx_reg, ny_reg;

    logic [NUM_W-1:0]  mag;
    logic [63:0]       dividend;

    assign en        = !out_valid_reg || out_ready;
    assign job_ready = en;

    assign mag      = job.num[NUM_W-1] ? -job.num : job.num;
    assign dividend = {mag, {D{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QUOT_W-1:0], job_valid};
            out_valid_reg <= v_reg[QUOT_W];
        end
    end

    // entry stage: quotients of 2^32 or more saturate outright
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0].hit  <= job.hit;
            meta_reg[0].neg  <= job.num[NUM_W-1];
            meta_reg[0].ovf  <= dividend[63:32] >= job.den;
            meta_reg[0].zero <= job.den == '0;
            meta_reg[0].nx   <= job.nx;
            meta_reg[0].ny   <= job.ny;
            den_reg[0]       <= job.den;
            rem_reg[0]       <= dividend[63:32];
            lo_reg[0]        <= dividend[31:0];
            q_reg[0]         <= '0;
        end
    end

    // one quotient bit per stage
    always_ff @(posedge clk)
    begin
        logic [DEN_W:0] trial;
        logic           take;
        if (en)
        begin
            for (int k = 0; k < QUOT_W; k++)
            begin
                trial = {rem_reg[k], lo_reg[k][QUOT_W-1-k]};
                take  = trial >= {1'b0, den_reg[k]};
                rem_reg[k+1]  <= take ? DEN_W'(trial - {1'b0, den_reg[k]}) : trial[DEN_W-1:0];
                q_reg[k+1]    <= {q_reg[k][QUOT_W-2:0], take};
                lo_reg[k+1]   <= lo_reg[k];
                den_reg[k+1]  <= den_reg[k];
                meta_reg[k+1] <= meta_reg[k];
            end
        end
    end

    always_comb
    begin
        meta_t             m;
        logic [QUOT_W-1:0] q;
        m = meta_reg[QUOT_W];
        q = q_reg[QUOT_W];
        if (!m.hit || m.zero)
        begin
            param_next = '0;
        end
        else if (m.neg)
        begin
            param_next = (m.ovf || (q[31] && (q[30:0] != '0))) ? 32'h8000_0000 : -q;
        end
        else
        begin
            param_next = (m.ovf || q[31]) ? 32'h7fff_ffff : q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= meta_reg[QUOT_W].hit;
            param_reg   <= param_next;
            nx_reg      <= meta_reg[QUOT_W].hit ? meta_reg[QUOT_W].nx : 16'h0000;
            ny_reg      <= meta_reg[QUOT_W].hit ? meta_reg[QUOT_W].ny : 16'h0000;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_data  = {ny_reg, nx_reg, param_reg};

endmodule

// ===== test/oriented_box_overlap_hit_unit_test.sv =====
// ----------------------------------------------------------------------------
// oriented_box_overlap_hit_unit_test
// Streams overlap queries into the hit unit and compares every returned
// result, field by field and in order, with a predicted one. A short table
// of hand-made queries comes first, then random ones, with random gaps on
// both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oriented_box_overlap_hit_unit_test;
    import obox_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_QUERIES = 1150;

    typedef struct packed {
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic signed [15:0] box_dir_x;
        logic signed [15:0] box_dir_y;
        logic [30:0]        box_half_width;
        logic [30:0]        box_half_length;
        logic signed [31:0] rect_x;
        logic signed [31:0] rect_y;
        logic signed [15:0] rect_dir_x;
        logic signed [15:0] rect_dir_y;
        logic [30:0]        rect_half_x;
        logic [30:0]        rect_half_y;
    } query_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_param;
        logic [15:0]        normal_x;
        logic [15:0]        normal_y;
    } contact_t;

    typedef struct {
        query_t   q;
        logic     known;
        contact_t res;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    contact_t   contact_q[$];
    int         mismatches;
    int         watchdog;
    logic       calm;
    row_t       table_rows[$];

    oriented_box_overlap_hit_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [IN_DATA_W-1:0] pack_query(query_t q);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[31:0]    = q.box_x;
        d[63:32]   = q.box_y;
        d[79:64]   = q.box_dir_x;
        d[95:80]   = q.box_dir_y;
        d[126:96]  = q.box_half_width;
        d[157:127] = q.box_half_length;
        d[189:158] = q.rect_x;
        d[221:190] = q.rect_y;
        d[237:222] = q.rect_dir_x;
        d[253:238] = q.rect_dir_y;
        d[284:254] = q.rect_half_x;
        d[315:285] = q.rect_half_y;
        return d;
    endfunction

    function automatic logic signed [127:0] mag(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat_quot(logic signed [127:0] b,
                                                    logic signed [127:0] den);
        logic signed [127:0] q;
        if (den == 0)
            return 0;
        q = (mag(b) <<< DIR_FRAC_BITS) / den;
        if (b < 0)
            return q > 128'sd2147483648 ? 32'sh8000_0000 : 32'(-q);
        return q > 128'sd2147483647 ? 32'sh7fff_ffff : 32'(q);
    endfunction

    function automatic contact_t predict_contact(query_t q);
        logic signed [127:0] bdx, bdy, rdx, rdy, hw, hl, rhx, rhy, dx, dy;
        logic signed [127:0] pl, pw, pla, pwa, dcr, ddr, ddb, dcb, b1, b2;
        contact_t r;
        bdx = q.box_dir_x;  bdy = q.box_dir_y;
        rdx = q.rect_dir_x; rdy = q.rect_dir_y;
        hw  = {97'd0, q.box_half_width};
        hl  = {97'd0, q.box_half_length};
        rhx = {97'd0, q.rect_half_x};
        rhy = {97'd0, q.rect_half_y};
        dx  = 128'(q.box_x) - 128'(q.rect_x);
        dy  = 128'(q.box_y) - 128'(q.rect_y);
        pl  = rdx * bdx + rdy * bdy;
        pw  = rdx * bdy - rdy * bdx;
        pla = mag(pl);
        pwa = mag(pw);
        dcr = dx * rdy - dy * rdx;
        ddr = dx * rdx + dy * rdy;
        ddb = dx * bdx + dy * bdy;
        dcb = dx * bdy - dy * bdx;
        r = '0;
        if (mag(dcr) > (rhy <<< DIR_FRAC_BITS) + ((pla * hw + pwa * hl) >>> DIR_FRAC_BITS))
            return r;
        if (mag(ddr) > (rhx <<< DIR_FRAC_BITS) + ((pwa * hw + pla * hl) >>> DIR_FRAC_BITS))
            return r;
        if (mag(ddb) > (hl <<< DIR_FRAC_BITS) + ((pla * rhx + pwa * rhy) >>> DIR_FRAC_BITS))
            return r;
        if (mag(dcb) > (hw <<< DIR_FRAC_BITS) + ((pwa * rhx + pla * rhy) >>> DIR_FRAC_BITS))
            return r;
        b1 = (pw > 0 ? dcb : -dcb) - (hw <<< DIR_FRAC_BITS);
        b2 = (pl > 0 ? ddb : -ddb) - (hl <<< DIR_FRAC_BITS);
        r.hit = 1'b1;
        if (b1 * pla > b2 * pwa)
        begin
            r.hit_param = sat_quot(b1, pwa);
            r.normal_x  = pw > 0 ? 16'(-bdy) : 16'(bdy);
            r.normal_y  = pw > 0 ? 16'(bdx) : 16'(-bdx);
        end
        else
        begin
            r.hit_param = sat_quot(b2, pla);
            r.normal_x  = pl > 0 ? 16'(-bdx) : 16'(bdx);
            r.normal_y  = pl > 0 ? 16'(-bdy) : 16'(bdy);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rand_dir();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        if (k < 3)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sd16384;
                1: return -16'sd16384;
                2: return 16'sd0;
                default: return 16'sh8000;
            endcase
        end
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     spread;
        spread = $urandom_range(0, 9);
        q.box_dir_x  = rand_dir();
        q.box_dir_y  = rand_dir();
        q.rect_dir_x = rand_dir();
        q.rect_dir_y = rand_dir();
        if (spread == 0)
        begin
            q.box_x = $urandom; q.box_y = $urandom;
            q.rect_x = $urandom; q.rect_y = $urandom;
            q.box_half_width = 31'($urandom); q.box_half_length = 31'($urandom);
            q.rect_half_x = 31'($urandom); q.rect_half_y = 31'($urandom);
        end
        else
        begin
            // mostly nearby boxes, so most queries overlap
            q.box_x  = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            q.box_y  = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            q.rect_x = q.box_x + $signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
            q.rect_y = q.box_y + $signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
            q.box_half_width  = 31'($urandom_range(0, 32'h003f_ffff));
            q.box_half_length = 31'($urandom_range(0, 32'h003f_ffff));
            q.rect_half_x     = 31'($urandom_range(0, 32'h003f_ffff));
            q.rect_half_y     = 31'($urandom_range(0, 32'h003f_ffff));
        end
        return q;
    endfunction

    function automatic query_t mk(int bx, int by, int bdx, int bdy, int hw, int hl,
                                  int rx, int ry, int rdx, int rdy, int rhx, int rhy);
        query_t q;
        q.box_x = bx; q.box_y = by; q.box_dir_x = 16'(bdx); q.box_dir_y = 16'(bdy);
        q.box_half_width = 31'(hw); q.box_half_length = 31'(hl);
        q.rect_x = rx; q.rect_y = ry; q.rect_dir_x = 16'(rdx); q.rect_dir_y = 16'(rdy);
        q.rect_half_x = 31'(rhx); q.rect_half_y = 31'(rhy);
        return q;
    endfunction

    task automatic add_row(query_t q, logic known, contact_t res);
        row_t r;
        r.q = q; r.known = known; r.res = res;
        table_rows.push_back(r);
    endtask

    task automatic send_query(query_t q);
        while (calm == 1'b0 && $urandom_range(0, 99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_query(q);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    query_t pending_query;
    assign pending_query = query_t'({s_axis_tdata[31:0], s_axis_tdata[63:32],
        s_axis_tdata[79:64], s_axis_tdata[95:80], s_axis_tdata[126:96],
        s_axis_tdata[157:127], s_axis_tdata[189:158], s_axis_tdata[221:190],
        s_axis_tdata[237:222], s_axis_tdata[253:238], s_axis_tdata[284:254],
        s_axis_tdata[315:285]});

    // push expectations on accept
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            contact_q.push_back(predict_contact(pending_query));
    end

    always @(posedge clk)
    begin
        contact_t got;
        contact_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hit       = m_axis_tuser;
            got.hit_param = m_axis_tdata[31:0];
            got.normal_x  = m_axis_tdata[47:32];
            got.normal_y  = m_axis_tdata[63:48];
            if (contact_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_res = contact_q.pop_front();
                if (got !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hit %b/%b param %h/%h nx %h/%h ny %h/%h",
                                 exp_res.hit, got.hit, exp_res.hit_param, got.hit_param,
                                 exp_res.normal_x, got.normal_x,
                                 exp_res.normal_y, got.normal_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!calm && $urandom_range(0, 99) < 13)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        contact_t none;
        contact_t res;
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        watchdog = 0;
        calm = 1'b0;
        // far apart: miss
        add_row(mk(32'h4000_0000, 0, 16384, 0, 65536, 65536,
                   32'hc000_0000, 0, 16384, 0, 65536, 65536), 1'b1, none);
        // extremes of coordinates
        add_row(mk(32'h7fff_ffff, 32'h7fff_ffff, 16384, 0, 0, 0,
                   32'h8000_0000, 32'h8000_0000, 0, 16384, 0, 0), 1'b1, none);
        // identical aligned boxes: zero centre offset
        add_row(mk(0, 0, 16384, 0, 65536, 65536, 0, 0, 16384, 0, 65536, 65536), 1'b0, none);
        // touching on an edge
        add_row(mk(131072, 0, 16384, 0, 65536, 65536, 0, 0, 16384, 0, 65536, 65536),
                1'b0, none);
        // just past touching
        add_row(mk(131073, 0, 16384, 0, 65536, 65536, 0, 0, 16384, 0, 65536, 65536),
                1'b0, none);
        // perpendicular directions, zero dot product divisor
        add_row(mk(0, 0, 0, 16384, 65536, 65536, 1000, 0, 16384, 0, 65536, 65536), 1'b0, none);
        // 45 degree rotation
        add_row(mk(0, 0, 11585, 11585, 65536, 131072, 5000, -7000, 16384, 0, 65536, 65536),
                1'b0, none);
        // all-zero directions, both divisors zero
        add_row(mk(0, 0, 0, 0, 100, 100, 0, 0, 0, 0, 100, 100), 1'b0, none);
        // negated -32768 direction component
        add_row(mk(0, 0, -32768, -32768, 65536, 65536, 0, 0, -32768, 0, 65536, 65536),
                1'b0, none);
        add_row(mk(10, 20, 0, -32768, 65536, 65536, 0, 0, 16384, -32768, 65536, 65536),
                1'b0, none);
        // maximum half sizes, parameter saturation
        add_row(mk(0, 0, 16384, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1, 0,
                   32'h7fff_ffff, 32'h7fff_ffff), 1'b0, none);
        add_row(mk(32'h7fff_ffff, 0, 16384, 1, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 1, 16384,
                   32'h7fff_ffff, 32'h7fff_ffff), 1'b0, none);
        // opposite directions, negative projections
        add_row(mk(-5000, 3000, -16384, 0, 65536, 200000, 0, 0, 16384, 0, 65536, 65536),
                1'b0, none);
        add_row(mk(3000, -5000, 0, -16384, 200000, 65536, 0, 0, 0, 16384, 65536, 65536),
                1'b0, none);
        // non-unit directions
        add_row(mk(100, 100, 32767, 12345, 65536, 65536, 0, 0, -20000, 32767, 65536, 65536),
                1'b0, none);
        // zero-size boxes at the same point
        add_row(mk(777, 777, 16384, 0, 0, 0, 777, 777, 16384, 0, 0, 0), 1'b0, none);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
        begin
            if (table_rows[i].known)
            begin
                res = predict_contact(table_rows[i].q);
                if (res !== table_rows[i].res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: prediction %h, typed %h", i, res,
                                 table_rows[i].res);
                end
            end
            send_query(table_rows[i].q);
        end
        s_axis_tvalid <= 1'b0;
        // hold off until the pipe drains
        while (contact_q.size() != 0)
            @(posedge clk);
        for (int n = 0; n < RANDOM_QUERIES; n++)
        begin
            calm = (n >= 400 && n < 600);
            send_query(rand_query());
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (contact_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
